/* rtl/core/spf_pkg.sv */
// Shared types and constants for the sensor packet framer with CRC-16.
// No dependencies; every module in rtl/core imports this package.
package spf_pkg;

    // Input beat: one sensor sample and its timestamp
    typedef struct packed {
        logic [31:0] sample_bits;
        logic [31:0] tick_time;
    } t_spf_in;

    // Output beat: one byte of the packet stream
    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_last;
    } t_spf_out;

    // Controller -> datapath commands
    typedef struct packed {
        logic       take_in;    // latch sample, advance counters, start packet 1
        logic       pkt2_init;  // start the status packet
        logic       emit;       // send byte at byte_idx
        logic [3:0] byte_idx;
        logic       pkt_end;
        logic       run_last;
    } t_spf_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic out_free;    // output register can take a byte this cycle
        logic status_due;  // current sample also triggers a status packet
        logic norm_done;   // count normalizer has settled
    } t_spf_stat;

    // Configuration register indexes
    localparam logic [1:0] SPF_REG_HEADER   = 2'd0;
    localparam logic [1:0] SPF_REG_POLY     = 2'd1;
    localparam logic [1:0] SPF_REG_INTERVAL = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  SPF_HEADER_RST   = 8'h00;
    localparam logic [15:0] SPF_POLY_RST     = 16'hA001;
    localparam logic [15:0] SPF_INTERVAL_RST = 16'd100;

    // Packet layout
    localparam logic [15:0] SPF_CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  SPF_TYPE_SAMPLE = 8'h01;
    localparam logic [7:0]  SPF_TYPE_STATUS = 8'h02;
    localparam logic [7:0]  SPF_LEN_SAMPLE  = 8'd8;
    localparam logic [7:0]  SPF_LEN_STATUS  = 8'd4;
    localparam logic [3:0]  SPF_IDX_CRC_LO  = 4'd11;  // first byte not covered by CRC
    localparam logic [3:0]  SPF_IDX_LAST    = 4'd12;

    // Float conversion
    localparam logic [7:0]  SPF_EXP_BIAS    = 8'd127;

endpackage

/* rtl/core/spf_ctrl.sv */
// Controller FSM of the sensor packet framer: sequences input accept,
// byte emission of the sample packet and the optional status packet.
// Depends on spf_pkg.
module spf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spf_pkg::t_spf_stat i_stat,
    output spf_pkg::t_spf_cmd  o_cmd
);
    import spf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEND = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic       r_second, n_second;
    logic       last_byte;

    assign last_byte = (r_idx == SPF_IDX_LAST);

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_second = r_second;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.byte_idx = r_idx;
        o_cmd.pkt_end  = last_byte;
        o_cmd.run_last = last_byte && (r_second || !i_stat.status_due);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state  = ST_SEND;
                    n_idx    = '0;
                    n_second = 1'b0;
                end
            end
            ST_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_idx = r_idx + 4'd1;
                    if (last_byte) begin
                        if (!r_second && i_stat.status_due) begin
                            n_state = ST_WAIT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_WAIT: begin
                if (i_stat.norm_done) begin
                    o_cmd.pkt2_init = 1'b1;
                    n_state  = ST_SEND;
                    n_idx    = '0;
                    n_second = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_second <= n_second;
        end
    end

endmodule

/* rtl/core/spf_dp.sv */
// Datapath of the sensor packet framer: config registers, counters,
// packet fields, bytewise CRC-16, count-to-float normalizer, output register.
// Depends on spf_pkg.
module spf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  spf_pkg::t_spf_in   i_in_data,
    input  spf_pkg::t_spf_cmd  i_cmd,
    output spf_pkg::t_spf_stat o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spf_pkg::t_spf_out  o_out_data
);
    import spf_pkg::*;

    // Reflected CRC-16 over one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    logic [7:0]  r_header;
    logic [15:0] r_poly;
    logic [15:0] r_interval;
    logic [31:0] r_count, n_count;
    logic [15:0] r_int, n_int;
    logic        r_status_due;
    logic        n_hit;

    logic [31:0] r_payload;
    logic [31:0] r_stamp;
    logic        r_is_status;
    logic [15:0] r_crc;
    logic [31:0] r_norm;
    logic [4:0]  r_pos;
    logic        norm_done;

    logic        r_out_valid;
    t_spf_out    r_out;
    logic        out_free;
    logic [7:0]  byte_sel;

    logic [23:0] man_trunc;
    logic        round_up;
    logic [24:0] man_sum;
    logic [7:0]  exp_val;
    logic [31:0] float_val;

    // Counter advance for a new sample
    assign n_count = r_count + 32'd1;
    assign n_int   = r_int + 16'd1;
    assign n_hit   = (n_int == r_interval);

    // Config and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header     <= SPF_HEADER_RST;
            r_poly       <= SPF_POLY_RST;
            r_interval   <= SPF_INTERVAL_RST;
            r_count      <= '0;
            r_int        <= '0;
            r_status_due <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    SPF_REG_HEADER:   r_header   <= i_cfg_data[7:0];
                    SPF_REG_POLY:     r_poly     <= i_cfg_data;
                    SPF_REG_INTERVAL: r_interval <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take_in) begin
                r_count      <= n_count;
                r_int        <= n_hit ? 16'd0 : n_int;
                r_status_due <= n_hit;
            end
        end
    end

    // Normalizer: one left shift per cycle until the MSB is set or the value is zero
    assign norm_done = r_norm[31] || (r_norm == 32'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_norm <= n_count;
            r_pos  <= 5'd31;
        end else if (!norm_done) begin
            r_norm <= {r_norm[30:0], 1'b0};
            r_pos  <= r_pos - 5'd1;
        end
    end

    // Round to nearest even and pack as IEEE single
    assign man_trunc = r_norm[31:8];
    assign round_up  = r_norm[7] && ((|r_norm[6:0]) || r_norm[8]);
    assign man_sum   = {1'b0, man_trunc} + {24'd0, round_up};
    assign exp_val   = SPF_EXP_BIAS + {3'd0, r_pos} + {7'd0, man_sum[24]};
    assign float_val = (r_norm == 32'd0) ? 32'd0 : {1'b0, exp_val, man_sum[22:0]};

    // Byte mux over the packet layout
    always_comb begin
        unique case (i_cmd.byte_idx)
            4'd0:  byte_sel = r_header;
            4'd1:  byte_sel = r_is_status ? SPF_TYPE_STATUS : SPF_TYPE_SAMPLE;
            4'd2:  byte_sel = r_is_status ? SPF_LEN_STATUS : SPF_LEN_SAMPLE;
            4'd3:  byte_sel = r_payload[7:0];
            4'd4:  byte_sel = r_payload[15:8];
            4'd5:  byte_sel = r_payload[23:16];
            4'd6:  byte_sel = r_payload[31:24];
            4'd7:  byte_sel = r_stamp[7:0];
            4'd8:  byte_sel = r_stamp[15:8];
            4'd9:  byte_sel = r_stamp[23:16];
            4'd10: byte_sel = r_stamp[31:24];
            4'd11: byte_sel = r_crc[7:0];
            default: byte_sel = r_crc[15:8];
        endcase
    end

    // Packet fields and running CRC
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_payload   <= i_in_data.sample_bits;
            r_stamp     <= i_in_data.tick_time;
            r_is_status <= 1'b0;
            r_crc       <= SPF_CRC_INIT;
        end else if (i_cmd.pkt2_init) begin
            r_payload   <= float_val;
            r_is_status <= 1'b1;
            r_crc       <= SPF_CRC_INIT;
        end else if (i_cmd.emit && (i_cmd.byte_idx < SPF_IDX_CRC_LO)) begin
            r_crc <= crc_byte(r_crc, byte_sel, r_poly);
        end
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte   <= byte_sel;
            r_out.packet_end <= i_cmd.pkt_end;
            r_out.run_last   <= i_cmd.run_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_stat.out_free   = out_free;
    assign o_stat.status_due = r_status_due;
    assign o_stat.norm_done  = norm_done;

endmodule

/* rtl/core/sensor_packet_framer_crc16.sv */
// Top level of the sensor packet framer with reflected CRC-16.
// Instantiates spf_ctrl and spf_dp; depends on spf_pkg.
//
//   Channel | Signals                                 | Beat
//   --------+-----------------------------------------+-------------------------
//   in      | i_in_valid, o_in_ready, i_in_data       | one sample + timestamp
//   out     | o_out_valid, i_out_ready, o_out_data    | one packet byte + flags
//   cfg     | i_cfg_we, i_cfg_idx, i_cfg_data         | one register write
//
// A sample is accepted, then its 13 byte beats are sent, with the CRC updated one
// byte per cycle as the bytes leave while the output is not stalled. When a status
// packet follows, it waits for the one-bit-per-cycle normalizer that turns the
// count into a float (it starts at accept and runs under the first packet).
// Reset is synchronous, active low, and needs no clearing pass.
// A stalled output holds its byte; the framer waits on it and takes no new sample
// until the last byte of the current one has been moved into the output register.
module sensor_packet_framer_crc16 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spf_pkg::t_spf_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spf_pkg::t_spf_out o_out_data
);
    import spf_pkg::*;

    t_spf_cmd  cmd;
    t_spf_stat stat;

    // Sequencer
    spf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Fields, CRC, counters, output register
    spf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/core/spf_checker.sv */
// Port-level checker for sensor_packet_framer_crc16, attached by bind.
// Depends on spf_pkg.
module spf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input spf_pkg::t_spf_out o_out_data
);
    import spf_pkg::*;

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // run_last only on the final byte of a packet
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.run_last |-> o_out_data.packet_end)
        else $error("run_last without packet_end");

    // A sample in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind sensor_packet_framer_crc16 spf_checker u_spf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* tb/testbench.sv */
// Self-checking testbench for sensor_packet_framer_crc16.
// Holds a byte-level model of the packet framer and compares every output beat with it.
// Depends on spf_pkg and the framer RTL only.
`timescale 1ns / 100ps

module testbench;
    import spf_pkg::*;

    // Register index that the framer decodes to nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         PKT_LEN    = 13;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = SPF_REG_HEADER;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_spf_in     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_spf_out    out_data;

    // Model state: configuration and counters
    logic [7:0]  m_header;
    logic [15:0] m_poly;
    logic [15:0] m_period;
    logic [31:0] m_count;
    logic [15:0] m_interval;

    t_spf_out    due_beats[$];
    int          n_errors   = 0;
    bit          send_idle  = 1'b1;
    bit          recv_idle  = 1'b1;
    int          stall_hold = 0;

    sensor_packet_framer_crc16 i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #4 clk = ~clk;

    // Unsigned count to IEEE single, round to nearest even
    function automatic logic [31:0] count_to_single(input logic [31:0] v);
        int          p;
        int          sh;
        logic [7:0]  ex;
        logic [31:0] man;
        logic [31:0] rem;
        logic [31:0] half;
        if (v == 0) return 32'd0;
        p = 31;
        while (!v[p]) p--;
        ex = SPF_EXP_BIAS + 8'(p);
        if (p <= 23) begin
            man = v << (23 - p);
        end else begin
            sh   = p - 23;
            rem  = v & ((32'd1 << sh) - 32'd1);
            half = 32'd1 << (sh - 1);
            man  = v >> sh;
            if (rem > half || (rem == half && man[0])) man++;
            if (man == (32'd1 << 24)) begin
                man = man >> 1;
                ex++;
            end
        end
        return {1'b0, ex, man[22:0]};
    endfunction

    // Build one 13-byte packet and queue its beats
    task automatic queue_packet(input logic [7:0] kind, input logic [7:0] len,
                                input logic [31:0] payload, input logic [31:0] stamp,
                                input bit ends_run);
        logic [7:0]  pkt[PKT_LEN];
        logic [15:0] crc;
        t_spf_out    beat;
        pkt[0] = m_header;
        pkt[1] = kind;
        pkt[2] = len;
        for (int i = 0; i < 4; i++) begin
            pkt[3 + i] = payload[8*i +: 8];
            pkt[7 + i] = stamp[8*i +: 8];
        end
        // reflected CRC, LSB first
        crc = SPF_CRC_INIT;
        for (int i = 0; i < int'(SPF_IDX_CRC_LO); i++) begin
            crc = crc ^ {8'h00, pkt[i]};
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ m_poly) : (crc >> 1);
        end
        pkt[11] = crc[7:0];
        pkt[12] = crc[15:8];
        for (int i = 0; i < PKT_LEN; i++) begin
            beat.out_byte   = pkt[i];
            beat.packet_end = (i == int'(SPF_IDX_LAST));
            beat.run_last   = (i == int'(SPF_IDX_LAST)) && ends_run;
            due_beats.push_back(beat);
        end
    endtask

    // Advance counters for one accepted sample and queue its packets
    task automatic frame_sample(input t_spf_in d);
        bit status;
        m_count    = m_count + 32'd1;
        m_interval = m_interval + 16'd1;
        status     = (m_interval == m_period);
        if (status) m_interval = '0;
        queue_packet(SPF_TYPE_SAMPLE, SPF_LEN_SAMPLE, d.sample_bits, d.tick_time, !status);
        if (status)
            queue_packet(SPF_TYPE_STATUS, SPF_LEN_STATUS, count_to_single(m_count),
                         d.tick_time, 1'b1);
    endtask

    // Register write, one cycle wide, mirrored into the model
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            SPF_REG_HEADER:   m_header = value[7:0];
            SPF_REG_POLY:     m_poly   = value;
            SPF_REG_INTERVAL: m_period = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one sample beat; valid stays up across back-to-back beats
    task automatic offer_sample(input t_spf_in d);
        int gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        frame_sample(d);
    endtask

    // Stop offering and wait for every queued byte, then let the block settle
    task automatic wait_until_flushed();
        in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic t_spf_in random_sample();
        t_spf_in d;
        d.sample_bits = $urandom;
        d.tick_time   = $urandom;
        case ($urandom_range(0, 7))
            0: d.sample_bits = '0;
            1: d.sample_bits = '1;
            2: d.tick_time   = '0;
            3: d.tick_time   = '1;
            default: ;
        endcase
        return d;
    endfunction

    function automatic t_spf_in mk_sample(input logic [31:0] s, input logic [31:0] t);
        t_spf_in d;
        d.sample_bits = s;
        d.tick_time   = t;
        return d;
    endfunction

    // Interval value that lands a status packet within the next few samples
    function automatic logic [15:0] near_period(input int ahead);
        int k;
        k = int'(m_interval) + ahead;
        return (k > 65535) ? 16'hFFFF : 16'(k);
    endfunction

    // ---------------------------------------------------------------- tests

    // Default registers with field extremes
    task automatic test_reset_defaults();
        offer_sample(mk_sample(32'h0000_0000, 32'h0000_0000));
        offer_sample(mk_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer_sample(mk_sample(32'hAAAA_AAAA, 32'h5555_5555));
        offer_sample(mk_sample(32'h5555_5555, 32'hAAAA_AAAA));
        wait_until_flushed();
    endtask

    // Register extremes, data masking and the unused index
    task automatic test_register_extremes();
        write_reg(SPF_REG_HEADER, 16'hFFFF);
        write_reg(SPF_REG_POLY, 16'hFFFF);
        write_reg(SPF_REG_INTERVAL, near_period(1));
        offer_sample(mk_sample(32'hFFFF_FFFF, 32'h0000_0000));
        offer_sample(mk_sample(32'h0000_0000, 32'hFFFF_FFFF));
        wait_until_flushed();
        write_reg(SPF_REG_HEADER, 16'hA500);
        write_reg(SPF_REG_POLY, 16'h0000);
        write_reg(SPF_REG_INTERVAL, 16'd1);
        offer_sample(mk_sample(32'h3F80_0000, 32'h0000_0001));
        offer_sample(mk_sample(32'h8000_0000, 32'h8000_0000));
        wait_until_flushed();
        // index 3 decodes to nothing; interval 1 must stay in force
        write_reg(REG_UNUSED, 16'h1234);
        offer_sample(mk_sample(32'h7F80_0000, 32'h1234_5678));
        wait_until_flushed();
        write_reg(SPF_REG_HEADER, 16'h00C3);
        write_reg(SPF_REG_POLY, SPF_POLY_RST);
        write_reg(SPF_REG_INTERVAL, 16'hFFFF);
        offer_sample(mk_sample(32'h7FC0_0001, 32'hDEAD_BEEF));
        wait_until_flushed();
    endtask

    // Interval hit, zero interval, interval at or below the counter;
    // the sender waits for every byte before each sample
    task automatic test_interval_corners();
        write_reg(SPF_REG_INTERVAL, near_period(2));
        repeat (2) begin
            offer_sample(random_sample());
            wait_until_flushed();
        end
        repeat (2) begin
            offer_sample(random_sample());
            wait_until_flushed();
        end
        // interval equal to the counter: it runs on toward the wrap
        write_reg(SPF_REG_INTERVAL, m_interval);
        offer_sample(random_sample());
        wait_until_flushed();
        write_reg(SPF_REG_INTERVAL, 16'd0);
        offer_sample(random_sample());
        wait_until_flushed();
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_output_stall();
        write_reg(SPF_REG_INTERVAL, near_period(3));
        send_idle  = 1'b0;
        stall_hold = 300;
        repeat (6) offer_sample(random_sample());
        wait_until_flushed();
        send_idle = 1'b1;
    endtask

    // Random phases: fresh registers, random idling, random samples
    task automatic test_random_traffic();
        int sent;
        int n;
        sent = 0;
        while (sent < 150) begin
            write_reg(SPF_REG_HEADER, 16'($urandom));
            case ($urandom_range(0, 4))
                0: write_reg(SPF_REG_POLY, SPF_POLY_RST);
                1: write_reg(SPF_REG_POLY, 16'h0000);
                2: write_reg(SPF_REG_POLY, 16'hFFFF);
                default: write_reg(SPF_REG_POLY, 16'($urandom));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(SPF_REG_INTERVAL, 16'($urandom_range(1, 65535)));
                1: write_reg(SPF_REG_INTERVAL, 16'd1);
                default: write_reg(SPF_REG_INTERVAL, near_period($urandom_range(1, 12)));
            endcase
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            n = $urandom_range(10, 25);
            repeat (n) offer_sample(random_sample());
            sent += n;
            wait_until_flushed();
        end
    endtask

    // ---------------------------------------------------------------- checker

    // Compare each accepted output beat with the oldest queued byte
    always @(posedge clk) begin
        t_spf_out want;
        if (rst_n && out_valid && out_ready) begin
            if (due_beats.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: unexpected beat byte=%h end=%b last=%b", $realtime,
                             out_data.out_byte, out_data.packet_end, out_data.run_last);
            end else begin
                want = due_beats.pop_front();
                if (out_data.out_byte !== want.out_byte
                        || out_data.packet_end !== want.packet_end
                        || out_data.run_last !== want.run_last) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: beat mismatch byte %h/%h end %b/%b last %b/%b (exp/got)",
                                 $realtime, want.out_byte, out_data.out_byte,
                                 want.packet_end, out_data.packet_end,
                                 want.run_last, out_data.run_last);
                end
            end
        end
    end

    // Receiver: random stalls per beat, plus an optional long hold-off
    initial begin
        int w;
        forever begin
            if (stall_hold > 0) begin
                out_ready <= 1'b0;
                repeat (stall_hold) @(posedge clk);
                stall_hold = 0;
            end
            w = recv_idle ? $urandom_range(0, 10) : 0;
            if (w > 0) begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(rst_n && out_valid)) @(posedge clk);
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        m_header   = SPF_HEADER_RST;
        m_poly     = SPF_POLY_RST;
        m_period   = SPF_INTERVAL_RST;
        m_count    = '0;
        m_interval = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_interval_corners();
        test_output_stall();
        test_random_traffic();

        wait_until_flushed();
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/spf_pkg.sv
rtl/core/spf_ctrl.sv
rtl/core/spf_dp.sv
rtl/core/sensor_packet_framer_crc16.sv
rtl/core/spf_checker.sv
tb/testbench.sv
